// File: rtl/rpn_pkg.sv
// rpn_pkg: command codes, error codes, payload structs and FSM states
// for the RPN stack calculator. No dependencies.
package rpn_pkg;

   typedef enum logic [3:0] {
      CMD_PUSH  = 4'd0,
      CMD_ADD   = 4'd1,
      CMD_SUB   = 4'd2,
      CMD_MUL   = 4'd3,
      CMD_DIV   = 4'd4,
      CMD_REM   = 4'd5,
      CMD_END   = 4'd6,
      CMD_PRINT = 4'd7,
      CMD_DUP   = 4'd8,
      CMD_SWAP  = 4'd9,
      CMD_CLEAR = 4'd10
   } cmd_code_type;

   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_EMPTY = 3'd1;
   localparam logic [2:0] ERR_FULL  = 3'd2;
   localparam logic [2:0] ERR_ZDIV  = 3'd3;
   localparam logic [2:0] ERR_SWAP  = 3'd4;

   typedef struct packed {
      logic [3:0]         cmd;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic               print_valid;
      logic signed [31:0] print_value;
      logic [2:0]         error;
      logic [7:0]         stack_depth;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD1,
      ST_RD2,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_DIVFIN,
      ST_WR2,
      ST_DONE
   } state_type;

   // divider handshake
   typedef struct packed {
      logic start;
      logic is_rem;
   } div_ctl_type;

   typedef struct packed {
      logic        done;
      logic        ovf;
   } div_sts_type;

endpackage

// File: rtl/rpn_stack_calculator.sv
// rpn_stack_calculator: top level; sequencer around the stack memory,
// multiplier and divider. Depends on rpn_pkg, rpn_stack_mem, rpn_divider.
//
//   channel | direction | payload
//   req_    | in        | rpn_pkg::req_type  (cmd, operand)
//   rsp_    | out       | rpn_pkg::rsp_type  (print_valid, print_value, error, depth)
//
// One command at a time. Every command first reads the top two entries
// through the registered memory read port (RD1, RD2), then executes (EXEC)
// and registers the result (DONE). Push, clear, print, end-line, dup and
// unknown codes go from EXEC straight to DONE; add, sub and swap add a
// write-back (WR2); mul adds a registered multiply (MUL) before it; rem and
// div run the divider unless the divisor is zero or the stack is empty, one quotient bit per cycle (32 and 48 bits).
// Reset (synchronous) empties the stack; memory contents are not cleared.
// The result register holds until the rsp_ transfer; the next req_ transfer
// is taken in the same cycle the result is taken or later, so no new
// command is accepted while one is in progress.
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rpn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rpn_pkg::rsp_type rsp_data
);
   import rpn_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int PW = $clog2(STACK_DEPTH + 1);
   localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

   state_type     state_ff, state_in;
   logic [PW-1:0] sp_ff, sp_in;
   logic [3:0]    cmd_ff, cmd_in;
   logic [31:0]   opnd_ff, opnd_in;
   logic [31:0]   b_ff, b_in, a_ff, a_in;
   logic [2:0]    err_ff, err_in;
   logic [63:0]   prod_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // memory port
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;

   rpn_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   div_ctl_type div_ctl;
   div_sts_type div_sts;
   logic [31:0] div_res;
   rpn_divider u_div (
      .clock(clock), .reset(reset), .ctl(div_ctl), .dividend(a_ff),
      .divisor(b_ff), .sts(div_sts), .result(div_res)
   );

   // arithmetic helpers
   logic [32:0] sum33, dif33;
   logic [31:0] sum_sat, dif_sat, mul_res;
   logic [63:0] mag;
   logic [48:0] rq;
   always_comb begin
      sum33 = {a_ff[31], a_ff} + {b_ff[31], b_ff};
      dif33 = {a_ff[31], a_ff} - {b_ff[31], b_ff};
      sum_sat = (sum33[32] != sum33[31]) ? (sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                         : sum33[31:0];
      dif_sat = (dif33[32] != dif33[31]) ? (dif33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                         : dif33[31:0];
      mag = prod_ff[63] ? 64'(-prod_ff) : prod_ff;
      rq  = 49'((mag + 64'd32768) >> 16);
      if (!prod_ff[63])
         mul_res = (rq > 49'h7FFF_FFFF) ? 32'h7FFF_FFFF : rq[31:0];
      else
         mul_res = (rq > 49'h8000_0000) ? 32'h8000_0000 : 32'(-rq[31:0]);
   end

   logic [AW-1:0] top_addr, nxt_addr;
   assign top_addr = AW'(sp_ff - PW'(1));
   assign nxt_addr = AW'(sp_ff - PW'(2));

   always_ff @(posedge clock) begin
      prod_ff <= $signed(a_ff) * $signed(b_ff);
   end

   always_comb begin
      state_in = state_ff; sp_in = sp_ff; cmd_in = cmd_ff; opnd_in = opnd_ff;
      b_in = b_ff; a_in = a_ff; err_in = err_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      wr_en = 1'b0; wr_addr = AW'(sp_ff); wr_data = a_ff;
      rd_addr = top_addr; div_ctl = '0;
      req_ready = 1'b0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd_in = req_data.cmd; opnd_in = req_data.operand;
               err_in = ERR_NONE; a_in = '0; b_in = '0;
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            // rd_data = top (read issued at the transfer); second entry next
            b_in = rd_data;
            rd_addr = nxt_addr;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            // hold the second entry's address for the execute cycle
            rd_addr = nxt_addr;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // rd_data = second
            state_in = ST_DONE;
            rsp_in = '0;
            case (cmd_ff) inside
               CMD_PUSH: begin
                  if (sp_ff < FULL) begin
                     wr_en = 1'b1; wr_data = opnd_ff; sp_in = sp_ff + PW'(1);
                  end else err_in = ERR_FULL;
               end
               CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REM: begin
                  if (sp_ff == '0) begin
                     b_in = '0; a_in = '0; err_in = ERR_EMPTY;
                  end else if (sp_ff == PW'(1)) begin
                     a_in = '0; err_in = ERR_EMPTY;
                  end else a_in = rd_data;
                  if ((cmd_ff == CMD_DIV || cmd_ff == CMD_REM) && b_ff == '0
                      && sp_ff != '0) begin
                     a_in = a_ff;
                     sp_in = sp_ff - PW'(1);
                     err_in = ERR_ZDIV;
                  end else if ((cmd_ff == CMD_DIV || cmd_ff == CMD_REM) && sp_ff == '0) begin
                     // empty pop yields zero divisor; error 1 stands
                     sp_in = '0;
                  end else begin
                     sp_in = (sp_ff >= PW'(2)) ? sp_ff - PW'(2) : '0;
                     if (cmd_ff == CMD_MUL) state_in = ST_MUL;
                     else if (cmd_ff == CMD_DIV || cmd_ff == CMD_REM) state_in = ST_DIV;
                     else state_in = ST_WR2;
                  end
               end
               CMD_END: begin
                  if (sp_ff != '0) begin
                     rsp_in.print_valid = 1'b1; rsp_in.print_value = b_ff;
                     sp_in = sp_ff - PW'(1);
                  end
               end
               CMD_PRINT: begin
                  rsp_in.print_valid = 1'b1;
                  if (sp_ff != '0) rsp_in.print_value = b_ff;
                  else err_in = ERR_EMPTY;
               end
               CMD_DUP: begin
                  if (sp_ff == '0) err_in = ERR_EMPTY;
                  else if (sp_ff == FULL) err_in = ERR_FULL;
                  else begin
                     wr_en = 1'b1; wr_data = b_ff; sp_in = sp_ff + PW'(1);
                  end
               end
               CMD_SWAP: begin
                  if (sp_ff < PW'(2)) err_in = ERR_SWAP;
                  else begin
                     wr_en = 1'b1; wr_addr = nxt_addr; wr_data = b_ff;
                     a_in = rd_data; state_in = ST_WR2;
                  end
               end
               CMD_CLEAR: sp_in = '0;
               default: ;
            endcase
         end
         ST_MUL: begin
            state_in = ST_WR2;  // prod_ff ready next
         end
         ST_DIV: begin
            div_ctl.start = 1'b1;
            div_ctl.is_rem = (cmd_ff == CMD_REM);
            state_in = ST_DIVFIN;
         end
         ST_DIVFIN: begin
            if (div_sts.done) begin
               a_in = div_res;
               state_in = ST_WR2;
               cmd_in = CMD_ADD; b_in = '0; // write a_ff+0 path
            end
         end
         ST_WR2: begin
            state_in = ST_DONE;
            if (cmd_ff == CMD_SWAP) begin
               wr_en = 1'b1; wr_addr = top_addr; wr_data = a_ff;
            end else begin
               // push binary result; sp already reduced so never full
               wr_en = 1'b1; wr_addr = AW'(sp_ff);
               wr_data = (cmd_ff == CMD_ADD) ? sum_sat :
                         (cmd_ff == CMD_SUB) ? dif_sat : mul_res;
               sp_in = sp_ff + PW'(1);
            end
         end
         ST_DONE: begin
            rsp_in.error = err_ff;
            rsp_in.stack_depth = 8'(sp_ff);
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in; opnd_ff <= opnd_in; a_ff <= a_in; b_ff <= b_in;
      err_ff <= err_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// File: rtl/rpn_divider.sv
// rpn_divider: iterative restoring divider, one quotient bit per cycle.
// Computes (a<<16)/b saturated, or a % b. Depends on rpn_pkg.
module rpn_divider (
   input  logic                clock,
   input  logic                reset,
   input  rpn_pkg::div_ctl_type ctl,
   input  logic signed [31:0]  dividend,
   input  logic signed [31:0]  divisor,
   output rpn_pkg::div_sts_type sts,
   output logic signed [31:0]  result
);
   import rpn_pkg::*;

   logic [47:0] num_ff, num_in;
   logic [47:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, rem_mode_ff, rem_mode_in;
   logic        done_ff, done_in;

   logic [31:0] mag_a, mag_b;
   logic [32:0] trial;
   logic [32:0] shifted;

   always_comb begin
      mag_a = dividend[31] ? 32'(-dividend) : dividend;
      mag_b = divisor[31] ? 32'(-divisor) : divisor;
      shifted = {rem_ff, num_ff[47]};
      trial = shifted - {1'b0, den_ff};
   end

   always_comb begin
      num_in = num_ff; quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      neg_q_in = neg_q_ff; neg_r_in = neg_r_ff; rem_mode_in = rem_mode_ff;
      if (ctl.start) begin
         rem_mode_in = ctl.is_rem;
         num_in   = ctl.is_rem ? {mag_a, 16'd0} : {mag_a, 16'd0};
         den_in   = mag_b;
         rem_in   = '0;
         quo_in   = '0;
         neg_q_in = dividend[31] ^ divisor[31];
         neg_r_in = dividend[31];
         // rem uses only the top 32 steps
         cnt_in   = ctl.is_rem ? 6'd32 : 6'd48;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[46:0], 1'b0};
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in; quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
      neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in; rem_mode_ff <= rem_mode_in;
   end

   // result formatting, combinational, valid while done is high (quotient held)
   logic [48:0] sq;
   logic        ovf;
   always_comb begin
      sq = neg_q_ff ? 49'(-{1'b0, quo_ff}) : {1'b0, quo_ff};
      ovf = 1'b0;
      if (rem_mode_ff) begin
         result = neg_r_ff ? 32'(-rem_ff) : rem_ff;
      end else if (!neg_q_ff && quo_ff > 48'h7FFF_FFFF) begin
         result = 32'h7FFF_FFFF; ovf = 1'b1;
      end else if (neg_q_ff && quo_ff > 48'h8000_0000) begin
         result = 32'h8000_0000; ovf = 1'b1;
      end else begin
         result = sq[31:0];
      end
   end
   assign sts.done = done_ff;
   assign sts.ovf  = ovf;
endmodule

// File: rtl/rpn_stack_mem.sv
// rpn_stack_mem: value stack storage, single port write, one synchronous
// read port with a registered output. Depends on nothing.
module rpn_stack_mem #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);
   logic [31:0] mem [DEPTH];
   logic [31:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// File: rtl/rpn_checker.sv
// rpn_checker: port-level assertions for rpn_stack_calculator, bound in.
// Depends on rpn_pkg.
module rpn_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rpn_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rpn_pkg::rsp_type rsp_data
);
   import rpn_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_no_print_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.print_valid |-> rsp_data.print_value == '0)
      else $error("print_value without print");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.error <= ERR_SWAP)
      else $error("bad error code");

   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while busy");
endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (.*);
